[design/twl_pkg.sv]
// ----------------------------------------------------------------------------
// twl_pkg: shared types and constants of the tiling window layout
// Register indexes, layout modes, divider widths and the divider interface.
// ----------------------------------------------------------------------------
`default_nettype none

package twl_pkg;

  // parameter defaults
  localparam int MaxWindowsDef  = 16;
  localparam int MinTileSizeDef = 16;

  // master fraction is given in thousandths
  localparam int FracDen = 1000;

  // divide by 1000 as a reciprocal multiply: ceil(2^29 / 1000),
  // exact for any product of a 12-bit width and a 10-bit fraction
  localparam int                  FracRcpW     = 20;
  localparam int                  FracRcpShift = 29;
  localparam logic [FracRcpW-1:0] FracRcp      = 20'd536871;

  // field widths
  localparam int CoordW   = 12;
  localparam int OutPosW  = 14;
  localparam int GapW     = 8;
  localparam int FracW    = 10;
  localparam int CountW   = 5;
  localparam int TileIdxW = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // shared divider: dividend holds a width or a height, divisor a window count
  localparam int DvdW = CoordW;
  localparam int DsrW = CountW;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgLayoutMode     = 2'd0,
    CfgInsetGap       = 2'd1,
    CfgMasterFraction = 2'd2
  } cfg_idx_e;

  // layout modes
  typedef enum logic [1:0] {
    ModeMaster  = 2'd0,
    ModeTall    = 2'd1,
    ModeWide    = 2'd2,
    ModeMonocle = 2'd3
  } layout_mode_e;

  // divider request and response
  typedef struct packed {
    logic            go;
    logic [DvdW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
    logic [DsrW-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

[design/twl_div.sv]
// ----------------------------------------------------------------------------
// twl_div: shared restoring divider
// One quotient bit per cycle; done pulses as the last bit is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module twl_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire twl_pkg::div_req_t req_i,
  output twl_pkg::div_rsp_t      rsp_o
);

  localparam int DvdW = twl_pkg::DvdW;
  localparam int DsrW = twl_pkg::DsrW;
  localparam int CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DsrW-1:0] dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q;
  logic            done_q;

  logic [DsrW:0]   trial;
  logic            ge;

  // one restoring step
  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? DsrW'(trial - {1'b0, dsr_q}) : DsrW'(trial);
    dvd_d = {dvd_q[DvdW-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(DvdW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

[design/tiling_window_layout.sv]
// ----------------------------------------------------------------------------
// tiling_window_layout: splits a screen area into one tile per window
// Master-stack, tall, wide and monocle layouts with inset gap and size clamp.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  command   | start_i, busy_o, area_*_i, window_count_i | in
//  tiles     | tile_valid_o, tile_*_o                    | out
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i          | in
//
//  A command transfer is taken when start_i is high and busy_o is low.
//  Master-stack keeps busy_o high through the width times fraction product, a
//  reciprocal multiply for the divide by 1000, the stack height through the
//  shared 12-bit bit-serial divider (start, quotient bits, done) and the tiles.
//  Tall and wide run one divide first; monocle or one window only the tiles.
//  One tile leaves per cycle with a one-cycle tile_valid_o strobe; the
//  receiver cannot stall. Reset clears the sequencer and loads the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tiling_window_layout #(
  parameter int MAX_WINDOWS   = twl_pkg::MaxWindowsDef,
  parameter int MIN_TILE_SIZE = twl_pkg::MinTileSizeDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output      logic                           busy_o,
  input  wire logic [twl_pkg::CoordW-1:0]     area_left_i,
  input  wire logic [twl_pkg::CoordW-1:0]     area_top_i,
  input  wire logic [twl_pkg::CoordW-1:0]     area_width_i,
  input  wire logic [twl_pkg::CoordW-1:0]     area_height_i,
  input  wire logic [twl_pkg::CountW-1:0]     window_count_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [twl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [twl_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output      logic                           tile_valid_o,
  output      logic [twl_pkg::OutPosW-1:0]    tile_left_o,
  output      logic [twl_pkg::OutPosW-1:0]    tile_top_o,
  output      logic [twl_pkg::CoordW-1:0]     tile_width_o,
  output      logic [twl_pkg::CoordW-1:0]     tile_height_o,
  output      logic [twl_pkg::TileIdxW-1:0]   tile_index_o,
  output      logic                           tile_last_o
);

  localparam int CW    = twl_pkg::CoordW;
  localparam int PW    = twl_pkg::OutPosW;
  localparam int GW    = twl_pkg::GapW;
  localparam int FW    = twl_pkg::FracW;
  localparam int DvdW  = twl_pkg::DvdW;
  localparam int DsrW  = twl_pkg::DsrW;
  localparam int PrdW  = CW + FW;
  localparam int RcpPW = PrdW + twl_pkg::FracRcpW;
  localparam int CntW  = $clog2(MAX_WINDOWS + 1);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StMwScale,
    StEachGo,
    StEachWait,
    StEmit
  } state_e;

  typedef enum logic [1:0] {
    KindFull,
    KindMaster,
    KindTall,
    KindWide
  } kind_e;

  // configuration registers
  logic [1:0]    mode_q;
  logic [GW-1:0] gap_q;
  logic [FW-1:0] frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= twl_pkg::ModeMaster;
      gap_q  <= '0;
      frac_q <= FW'(550);
    end else if (cfg_we_i) begin
      case (twl_pkg::cfg_idx_e'(cfg_idx_i))
        twl_pkg::CfgLayoutMode:     mode_q <= cfg_wdata_i[1:0];
        twl_pkg::CfgInsetGap:       gap_q  <= cfg_wdata_i[GW-1:0];
        twl_pkg::CfgMasterFraction: frac_q <= cfg_wdata_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // command registers and sequencer state
  state_e          state_q;
  kind_e           kind_q;
  logic [CW-1:0]   ax_q, ay_q, aw_q, ah_q;
  logic [CntW-1:0] n_q, idx_q;
  logic [PrdW-1:0] prod_q;
  logic [CW-1:0]   mw_q, each_q;
  logic [DsrW-1:0] rem_q;
  logic [PW-1:0]   x_q, y_q;

  // saturated count and fraction
  logic [CntW-1:0] n_sat;
  logic [FW-1:0]   frac_sat;

  always_comb begin
    if (32'(window_count_i) > MAX_WINDOWS) n_sat = CntW'(MAX_WINDOWS);
    else                                   n_sat = CntW'(window_count_i);
    frac_sat = (frac_q > FW'(twl_pkg::FracDen)) ? FW'(twl_pkg::FracDen) : frac_q;
  end

  // master width: product over 1000 by reciprocal multiply
  logic [RcpPW-1:0] mw_prod;

  always_comb begin
    mw_prod = RcpPW'(prod_q) * RcpPW'(twl_pkg::FracRcp);
  end

  // shared divider
  twl_pkg::div_req_t div_req;
  twl_pkg::div_rsp_t div_rsp;

  always_comb begin
    div_req.go       = (state_q == StEachGo);
    div_req.dividend = (kind_q == KindTall) ? DvdW'(aw_q) : DvdW'(ah_q);
    div_req.divisor  = (kind_q == KindMaster) ? DsrW'(n_q - 1'b1) : DsrW'(n_q);
  end

  twl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // tile of the current index before the inset
  logic          is_last;
  logic [CW-1:0] seg, w_raw, h_raw;

  always_comb begin
    is_last = (idx_q == n_q - 1'b1);
    seg     = is_last ? CW'(each_q + CW'(rem_q)) : each_q;
    w_raw   = aw_q;
    h_raw   = ah_q;
    case (kind_q)
      KindMaster: begin
        if (idx_q == '0) begin
          w_raw = mw_q;
        end else begin
          w_raw = CW'(aw_q - mw_q);
          h_raw = seg;
        end
      end
      KindTall: w_raw = seg;
      KindWide: h_raw = seg;
      default: ;
    endcase
  end

  // inset and clamp
  logic signed [PW-1:0] w_ins, h_ins;
  logic [CW-1:0]        w_out, h_out;
  logic [PW-1:0]        x_out, y_out;

  always_comb begin
    w_ins = $signed(PW'(w_raw)) - $signed(PW'(gap_q));
    h_ins = $signed(PW'(h_raw)) - $signed(PW'(gap_q));
    w_out = (w_ins < $signed(PW'(MIN_TILE_SIZE))) ? CW'(MIN_TILE_SIZE) : CW'(w_ins);
    h_out = (h_ins < $signed(PW'(MIN_TILE_SIZE))) ? CW'(MIN_TILE_SIZE) : CW'(h_ins);
    x_out = PW'(x_q + PW'(gap_q >> 1));
    y_out = PW'(y_q + PW'(gap_q >> 1));
  end

  // sequencer and tile output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      kind_q       <= KindFull;
      tile_valid_o <= 1'b0;
    end else begin
      tile_valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            if (n_sat == '0) begin
              state_q <= StIdle;
            end else if (n_sat == CntW'(1) || mode_q == twl_pkg::ModeMonocle) begin
              kind_q  <= KindFull;
              state_q <= StEmit;
            end else if (mode_q == twl_pkg::ModeMaster) begin
              kind_q  <= KindMaster;
              state_q <= StMul;
            end else if (mode_q == twl_pkg::ModeTall) begin
              kind_q  <= KindTall;
              state_q <= StEachGo;
            end else begin
              kind_q  <= KindWide;
              state_q <= StEachGo;
            end
          end
        end
        StMul:      state_q <= StMwScale;
        StMwScale:  state_q <= StEachGo;
        StEachGo:   state_q <= StEachWait;
        StEachWait: if (div_rsp.done) state_q <= StEmit;
        StEmit: begin
          tile_valid_o <= 1'b1;
          if (is_last) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        ax_q  <= area_left_i;
        ay_q  <= area_top_i;
        aw_q  <= area_width_i;
        ah_q  <= area_height_i;
        n_q   <= n_sat;
        idx_q <= '0;
        x_q   <= PW'(area_left_i);
        y_q   <= PW'(area_top_i);
      end
      StMul:     prod_q <= PrdW'(aw_q) * PrdW'(frac_sat);
      StMwScale: mw_q   <= CW'(mw_prod >> twl_pkg::FracRcpShift);
      StEachWait: begin
        if (div_rsp.done) begin
          each_q <= CW'(div_rsp.quotient);
          rem_q  <= div_rsp.remainder;
        end
      end
      StEmit: begin
        tile_left_o   <= x_out;
        tile_top_o    <= y_out;
        tile_width_o  <= w_out;
        tile_height_o <= h_out;
        tile_index_o  <= twl_pkg::TileIdxW'(idx_q);
        tile_last_o   <= is_last;
        idx_q         <= idx_q + 1'b1;
        // advance the origin for the next tile
        case (kind_q)
          KindMaster: begin
            if (idx_q == '0) x_q <= PW'(x_q + PW'(mw_q));
            else             y_q <= PW'(y_q + PW'(each_q));
          end
          KindTall: x_q <= PW'(x_q + PW'(each_q));
          KindWide: y_q <= PW'(y_q + PW'(each_q));
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for tiling_window_layout
// Sends screen areas and window counts under several register settings, and
// predicts every tile from a behavioral layout calculator in the scoreboard.
// Each tile strobe is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

import twl_pkg::*;

// one tile as it leaves the block
typedef struct packed {
  logic [OutPosW-1:0]  left;
  logic [OutPosW-1:0]  top;
  logic [CoordW-1:0]   width;
  logic [CoordW-1:0]   height;
  logic [TileIdxW-1:0] idx;
  logic                last;
} tile_t;

// one layout command
typedef struct packed {
  logic [CoordW-1:0] left;
  logic [CoordW-1:0] top;
  logic [CoordW-1:0] width;
  logic [CoordW-1:0] height;
  logic [CountW-1:0] count;
} layout_cmd_t;

class tile_scoreboard;
  tile_t        tile_q[$];
  int unsigned  mismatches = 0;
  layout_mode_e mode       = ModeMaster;
  int           gap        = 0;
  int           fraction   = 550;

  // mirror of the register file; unused indexes are dropped
  function void apply_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgLayoutMode:     mode = layout_mode_e'(data[1:0]);
      CfgInsetGap:       gap = int'(data[GapW-1:0]);
      CfgMasterFraction: fraction = int'(data[FracW-1:0]);
      default: ;
    endcase
  endfunction

  // inset by the gap, clamp the size, truncate to port widths
  function void push_tile(int idx, int last_idx, int x, int y, int w, int h);
    tile_t t;
    x = x + gap / 2;
    y = y + gap / 2;
    w = w - gap;
    h = h - gap;
    if (w < MinTileSizeDef) w = MinTileSizeDef;
    if (h < MinTileSizeDef) h = MinTileSizeDef;
    t.left   = x[OutPosW-1:0];
    t.top    = y[OutPosW-1:0];
    t.width  = w[CoordW-1:0];
    t.height = h[CoordW-1:0];
    t.idx    = idx[TileIdxW-1:0];
    t.last   = (idx == last_idx);
    tile_q.push_back(t);
  endfunction

  // expected tiles of one accepted command
  function void note_command(layout_cmd_t c);
    int ax, ay, aw, ah, n, f, mw, cnt, each, rem, i;
    ax = int'(c.left);
    ay = int'(c.top);
    aw = int'(c.width);
    ah = int'(c.height);
    n  = int'(c.count);
    if (n > MaxWindowsDef) n = MaxWindowsDef;
    if (n == 0) return;
    if (n == 1 || mode == ModeMonocle) begin
      for (i = 0; i < n; i++) push_tile(i, n - 1, ax, ay, aw, ah);
      return;
    end
    case (mode)
      ModeMaster: begin
        f = (fraction > FracDen) ? FracDen : fraction;
        mw = aw * f / FracDen;
        push_tile(0, n - 1, ax, ay, mw, ah);
        cnt  = n - 1;
        each = ah / cnt;
        rem  = ah - each * cnt;
        for (i = 0; i < cnt; i++)
          push_tile(i + 1, n - 1, ax + mw, ay + i * each, aw - mw,
                    each + ((i == cnt - 1) ? rem : 0));
      end
      ModeTall: begin
        each = aw / n;
        rem  = aw - each * n;
        for (i = 0; i < n; i++)
          push_tile(i, n - 1, ax + i * each, ay, each + ((i == n - 1) ? rem : 0), ah);
      end
      default: begin
        each = ah / n;
        rem  = ah - each * n;
        for (i = 0; i < n; i++)
          push_tile(i, n - 1, ax, ay + i * each, aw, each + ((i == n - 1) ? rem : 0));
      end
    endcase
  endfunction

  // compare one received tile with the oldest prediction
  function void check_tile(tile_t got);
    tile_t want;
    if (tile_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected tile idx=%0d left=%0d top=%0d w=%0d h=%0d last=%0b",
                 $realtime, got.idx, got.left, got.top, got.width, got.height, got.last);
      return;
    end
    want = tile_q.pop_front();
    if (got.left !== want.left || got.top !== want.top || got.width !== want.width ||
        got.height !== want.height || got.idx !== want.idx || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: tile mismatch", $realtime);
        $display("  expected idx=%0d left=%0d top=%0d w=%0d h=%0d last=%0b",
                 want.idx, want.left, want.top, want.width, want.height, want.last);
        $display("  actual   idx=%0d left=%0d top=%0d w=%0d h=%0d last=%0b",
                 got.idx, got.left, got.top, got.width, got.height, got.last);
      end
    end
  endfunction

  function int pending();
    return tile_q.size();
  endfunction
endclass

module tb;

  localparam int DrainCycles = 80;
  localparam int CycleLimit  = 200000;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CoordW-1:0]   area_left_i;
  logic [CoordW-1:0]   area_top_i;
  logic [CoordW-1:0]   area_width_i;
  logic [CoordW-1:0]   area_height_i;
  logic [CountW-1:0]   window_count_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                tile_valid_o;
  logic [OutPosW-1:0]  tile_left_o;
  logic [OutPosW-1:0]  tile_top_o;
  logic [CoordW-1:0]   tile_width_o;
  logic [CoordW-1:0]   tile_height_o;
  logic [TileIdxW-1:0] tile_index_o;
  logic                tile_last_o;

  tile_scoreboard sb = new;
  int unsigned    cycle_count;

  tiling_window_layout dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tile monitor
  always @(posedge clk_i) begin
    if (rst_ni && tile_valid_o)
      sb.check_tile({tile_left_o, tile_top_o, tile_width_o, tile_height_o,
                     tile_index_o, tile_last_o});
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // one command transfer after an idle stretch of the given length
  task automatic issue_layout(input layout_cmd_t c, input int idle);
    if (idle > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (idle - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    area_left_i    <= c.left;
    area_top_i     <= c.top;
    area_width_i   <= c.width;
    area_height_i  <= c.height;
    window_count_i <= c.count;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_command(c);
  endtask

  // stop sending and wait until all tiles are out and the block is quiet
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.apply_write(idx, data);
  endtask

  // all registers, with random bits above the mode and gap fields and a stray write
  task automatic configure(input int mode, input int gap, input int frac);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    write_reg(CfgLayoutMode, {junk[CfgDataW-1:2], mode[1:0]});
    junk = CfgDataW'($urandom);
    write_reg(CfgInsetGap, {junk[CfgDataW-1:GapW], gap[GapW-1:0]});
    write_reg(CfgMasterFraction, frac[FracW-1:0]);
    write_reg(CfgIdxUnused, CfgDataW'($urandom));
  endtask

  function automatic layout_cmd_t mk(int l, int t, int w, int h, int n);
    layout_cmd_t c;
    c.left   = l[CoordW-1:0];
    c.top    = t[CoordW-1:0];
    c.width  = w[CoordW-1:0];
    c.height = h[CoordW-1:0];
    c.count  = n[CountW-1:0];
    return c;
  endfunction

  // coordinates lean toward the edges and tiny sizes
  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CoordW'($urandom_range(0, 40));
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic layout_cmd_t rand_cmd();
    layout_cmd_t c;
    c.left   = rand_coord();
    c.top    = rand_coord();
    c.width  = rand_coord();
    c.height = rand_coord();
    case ($urandom_range(0, 11))
      0:       c.count = '0;
      1:       c.count = CountW'($urandom_range(17, 31));
      2:       c.count = 5'd1;
      3:       c.count = 5'd16;
      default: c.count = CountW'($urandom_range(2, 16));
    endcase
    return c;
  endfunction

  initial begin
    int mode, gap, frac, p, k;
    bit idle_on;

    rst_ni         = 1'b0;
    start_i        = 1'b0;
    area_left_i    = '0;
    area_top_i     = '0;
    area_width_i   = '0;
    area_height_i  = '0;
    window_count_i = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, count extremes, tiny and full areas
    issue_layout(mk(100, 50, 1920, 1080, 0), $urandom_range(0, 15));
    issue_layout(mk(100, 50, 1920, 1080, 1), $urandom_range(0, 15));
    issue_layout(mk(0, 0, 1920, 1080, 2), $urandom_range(0, 15));
    issue_layout(mk(4095, 4095, 4095, 4095, 16), $urandom_range(0, 15));
    issue_layout(mk(10, 20, 800, 600, 17), $urandom_range(0, 15));
    issue_layout(mk(0, 0, 0, 0, 31), $urandom_range(0, 15));
    settle();
    configure(ModeTall, 255, 1023);
    issue_layout(mk(4095, 0, 4095, 4095, 3), 0);
    issue_layout(mk(0, 4095, 30, 30, 16), 0);
    issue_layout(mk(12, 34, 1000, 500, 1), 0);
    settle();
    configure(ModeWide, 1, 0);
    issue_layout(mk(0, 0, 4095, 4095, 7), $urandom_range(0, 15));
    issue_layout(mk(5, 5, 100, 10, 16), $urandom_range(0, 15));
    settle();
    configure(ModeMonocle, 7, 1000);
    issue_layout(mk(1, 2, 300, 200, 4), $urandom_range(0, 15));
    issue_layout(mk(4095, 4095, 0, 0, 16), $urandom_range(0, 15));
    settle();
    // fraction above one thousand saturates
    configure(ModeMaster, 254, 1023);
    issue_layout(mk(0, 0, 4095, 4095, 2), 0);
    issue_layout(mk(200, 100, 1000, 3000, 5), 0);
    settle();
    configure(ModeMaster, 0, 0);
    issue_layout(mk(0, 0, 4095, 4095, 3), 0);
    issue_layout(mk(7, 7, 2048, 15, 16), 0);
    settle();
    configure(ModeMaster, 16, 1000);
    issue_layout(mk(0, 0, 4095, 4095, 4), $urandom_range(0, 15));
    issue_layout(mk(300, 300, 1, 4095, 9), $urandom_range(0, 15));

    // random phases, each under its own register setting
    for (p = 0; p < 8; p++) begin
      settle();
      mode = (p < 4) ? p : $urandom_range(0, 3);
      gap  = (p == 0) ? 0 : (p == 1) ? 255 : $urandom_range(0, 255);
      case (p)
        2:       frac = 1023;
        3:       frac = 0;
        4:       frac = 1000;
        default: frac = $urandom_range(0, 1023);
      endcase
      configure(mode, gap, frac);
      idle_on = (p % 3) != 2;
      for (k = 0; k < 25; k++) begin
        // now and then hold off until every tile is out
        if ($urandom_range(0, 19) == 0) settle();
        issue_layout(rand_cmd(), idle_on ? $urandom_range(0, 15) : 0);
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/twl_pkg.sv
design/twl_div.sv
design/tiling_window_layout.sv
tb/sv/tb.sv
